// ----- rtl/bpfa_pkg.sv -----
package bpfa_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC_ONE = 3'd0,
    CMD_ALLOC_RUN = 3'd1,
    CMD_MARK_ONE  = 3'd2,
    CMD_FREE_ONE  = 3'd3,
    CMD_MARK_RUN  = 3'd4,
    CMD_FREE_RUN  = 3'd5,
    CMD_BAD6      = 3'd6,
    CMD_BAD7      = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] page_index;
    logic [16:0] page_count;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] found_index;
    logic [16:0] free_pages;
    logic [16:0] used_pages;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    logic        is_alloc;
    logic        is_run;
    logic        is_mark;
    logic        is_free;
    logic        is_bad;
    logic [15:0] page_index;
    logic [16:0] page_count;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WAIT,
    ST_CHK,
    ST_WR,
    ST_DONE
  } st_e;

endpackage

// ----- rtl/bpfa_front.sv -----
module bpfa_front
  import bpfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic op_valid_o,
  input  logic op_take_i,
  output op_t  op_o
);

  op_t  q_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  op_t  cls;

  always_comb begin
    cls            = '0;
    cls.page_index = req_i.page_index;
    cls.page_count = req_i.page_count;
    unique case (cmd_e'(req_i.command))
      CMD_ALLOC_ONE: begin cls.is_alloc = 1'b1; cls.page_count = 17'd1; end
      CMD_ALLOC_RUN: begin cls.is_alloc = 1'b1; cls.is_run = 1'b1; end
      CMD_MARK_ONE:  begin cls.is_mark = 1'b1; cls.page_count = 17'd1; end
      CMD_FREE_ONE:  begin cls.is_free = 1'b1; cls.page_count = 17'd1; end
      CMD_MARK_RUN:  begin cls.is_mark = 1'b1; cls.is_run = 1'b1; end
      CMD_FREE_RUN:  begin cls.is_free = 1'b1; cls.is_run = 1'b1; end
      default:       cls.is_bad = 1'b1;
    endcase
  end

  assign full       = cnt_q[1];
  assign op_valid_o = cnt_q != 2'd0;
  assign op_o       = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push && !full) q_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push && !full) wp_q <= ~wp_q;
      if (op_take_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'(op_take_i ? 1 : 0);
    end
  end

endmodule

// ----- rtl/bpfa_back.sv -----
module bpfa_back
  import bpfa_pkg::*;
#(
  parameter int NUM_PAGES     = 65536,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [16:0] usable_i,
  input  logic        op_valid_i,
  output logic        op_take_o,
  input  op_t         op_i,
  output logic        rsp_valid_o,
  input  logic        rsp_take_i,
  output rsp_t        rsp_o
);

  // map word width rounded up to a power of two
  localparam int BW    = $clog2(MAP_WORD_BITS);
  localparam int WB    = 1 << BW;
  localparam int WORDS = (NUM_PAGES + WB - 1) / WB;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  // page pointers hold any page index, count and limit
  localparam int PW    = ($clog2(NUM_PAGES) + 1 > 17) ? $clog2(NUM_PAGES) + 1 : 17;
  localparam int CLRW  = WW + 1;

  logic [WB-1:0]   mem [WORDS];
  logic [WB-1:0]   rd_q;
  logic [CLRW-1:0] clr_q;
  logic            clearing;

  st_e st_q, st_d;
  op_t op_q;
  logic [PW-1:0] p_q, hint_q, start_q, run_q, lim;
  logic          pass_q;   // 0 search pass, 1 apply pass
  logic [16:0]   used_q;
  logic          ok_q;
  logic [15:0]   found_q;
  logic          rsp_v_q;
  rsp_t          rsp_q;

  logic [PW-1:0] n_pages;
  logic [WW-1:0] widx;
  logic [BW-1:0] bidx;
  logic          bit_used;
  logic [PW-1:0] cnt_ext, end_p, next_p;
  logic          early_done, srch, found_now, last_pg;
  logic          do_wr;
  logic          new_bit;

  assign n_pages = PW'(NUM_PAGES);
  assign lim = (PW'(usable_i) < n_pages) ? PW'(usable_i) : n_pages;

  assign clearing = clr_q < CLRW'(WORDS);

  assign widx     = WW'(p_q >> BW);
  assign bidx     = p_q[BW-1:0];
  assign bit_used = rd_q[bidx];

  assign cnt_ext = PW'(op_q.page_count);
  assign end_p   = start_q + cnt_ext;
  assign next_p  = p_q + PW'(1);

  // commands that finish without touching the map
  assign early_done = op_i.is_bad || op_i.page_count == 17'd0 ||
                      (!op_i.is_alloc && PW'(op_i.page_index) >= lim) ||
                      (op_i.is_alloc && hint_q >= lim);
  assign srch      = op_q.is_alloc && !pass_q;
  assign found_now = !bit_used && run_q + PW'(1) == cnt_ext;
  assign last_pg   = next_p >= lim || next_p == end_p;

  assign op_take_o   = st_q == ST_IDLE && op_valid_i && !clearing && !rsp_v_q;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (op_take_o) st_d = early_done ? ST_DONE : ST_RD;
      ST_RD:   st_d = ST_WAIT;
      ST_WAIT: st_d = ST_CHK;
      ST_CHK:  st_d = ST_WR;
      ST_WR: begin
        if (srch) st_d = (!found_now && next_p >= lim) ? ST_DONE : ST_RD;
        else      st_d = last_pg ? ST_DONE : ST_RD;
      end
      ST_DONE: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // one page per read-check-write round; simple and exact
  always_comb begin
    do_wr = 1'b0; new_bit = 1'b0;
    if (pass_q || op_q.is_mark) begin
      do_wr   = !bit_used;
      new_bit = 1'b1;
    end else if (op_q.is_free) begin
      do_wr   = bit_used;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_RD) rd_q <= mem[widx];
    if (clearing) mem[WW'(clr_q)] <= '0;
    else if (st_q == ST_WR && do_wr) begin
      mem[widx] <= new_bit ? (rd_q | (WB'(1) << bidx))
                           : (rd_q & ~(WB'(1) << bidx));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; clr_q <= '0; hint_q <= '0; used_q <= '0;
      rsp_v_q <= 1'b0; pass_q <= 1'b0; p_q <= '0; start_q <= '0; run_q <= '0;
      ok_q <= 1'b0; found_q <= '0; op_q <= '0; rsp_q <= '0;
    end else begin
      st_q <= st_d;
      if (clearing) clr_q <= clr_q + CLRW'(1);
      if (st_q == ST_DONE) rsp_v_q <= 1'b1;
      else if (rsp_take_i) rsp_v_q <= 1'b0;
      if (op_take_o) begin
        op_q <= op_i; pass_q <= 1'b0; run_q <= '0; found_q <= '0;
        ok_q <= !op_i.is_bad && !op_i.is_alloc;
        start_q <= PW'(op_i.page_index);
        p_q <= op_i.is_alloc ? hint_q : PW'(op_i.page_index);
      end
      if (st_q == ST_WR) begin
        if (srch) begin
          // search pass
          if (!bit_used) begin
            if (run_q == '0) start_q <= p_q;
            if (found_now) begin
              pass_q <= 1'b1;
              p_q <= (run_q == '0) ? p_q : start_q;
              hint_q <= op_q.is_run ? p_q + PW'(1) : p_q;
              ok_q <= 1'b1;
              found_q <= 16'((run_q == '0) ? p_q : start_q);
            end else begin
              run_q <= run_q + PW'(1);
              p_q <= next_p;
              if (next_p >= lim) hint_q <= lim;
            end
          end else begin
            run_q <= '0; p_q <= next_p;
            if (next_p >= lim) hint_q <= lim;
          end
        end else begin
          if (do_wr) used_q <= new_bit ? used_q + 17'd1 : used_q - 17'd1;
          if (op_q.is_free && hint_q > p_q) hint_q <= p_q;
          p_q <= next_p;
        end
      end
      if (st_q == ST_DONE) begin
        rsp_q.ok          <= ok_q;
        rsp_q.found_index <= found_q;
        rsp_q.used_pages  <= used_q;
        rsp_q.free_pages  <= (17'(lim) > used_q) ? 17'(lim) - used_q : 17'd0;
      end
    end
  end

endmodule

// ----- rtl/bitmap_page_frame_allocator.sv -----
// Bitmap page frame allocator with a next-fit hint. Commands enter through a
// two-entry queue, a sequencer walks the page map one page per round of
// read, read-data register, check and write states; an allocation visits
// its search span and then its pages once more. The single map memory port
// sets that pace, and a waiting result holds the sequencer until popped.
// After reset a clearing pass of one cycle per map word zeroes the map; items
// wait meanwhile, configuration writes are taken at once.
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int NUM_PAGES     = 65536,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  req_t        req_i,
  output logic        empty,
  input  logic        pop,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);

  logic [16:0] usable_q;
  logic        op_valid, op_take, rsp_valid;
  op_t         op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) usable_q <= 17'h10000;
    else if (cfg_valid_i) usable_q <= cfg_data_i;
  end

  bpfa_front u_front (
    .clk_i, .rst_ni, .push, .full, .req_i,
    .op_valid_o(op_valid), .op_take_i(op_take), .op_o(op)
  );

  bpfa_back #(.NUM_PAGES(NUM_PAGES), .MAP_WORD_BITS(MAP_WORD_BITS)) u_back (
    .clk_i, .rst_ni, .usable_i(usable_q),
    .op_valid_i(op_valid), .op_take_o(op_take), .op_i(op),
    .rsp_valid_o(rsp_valid), .rsp_take_i(pop && !empty), .rsp_o
  );

  // transfer out when a result waits
  assign empty = !rsp_valid;

endmodule

// ----- rtl/bpfa_checker.sv -----
module bpfa_checker
  import bpfa_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input rsp_t rsp_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(rsp_o)) else $error("result dropped");
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !rsp_o.ok |-> rsp_o.found_index == 16'd0) else $error("bad index");
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> {1'b0, rsp_o.used_pages} + {1'b0, rsp_o.free_pages} <= 18'h10000
    || rsp_o.free_pages == 17'd0) else $error("counts");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_chk (.*);
